// ===== src/som_train_and_classify_core_defines.svh =====
// Assertion macros for the self-organising map core.
// Included by the top level; no other dependencies.
`ifndef SOM_TRAIN_AND_CLASSIFY_CORE_DEFINES_SVH
`define SOM_TRAIN_AND_CLASSIFY_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SOM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SOM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SOM_ASSERT(lbl, prop, msg)
`define SOM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/som_pkg.sv =====
// Shared types and constants for the self-organising map core.
// No dependencies.
package som_pkg;
    localparam int CRD_W = 6;
    localparam logic [15:0] ONE_Q14     = 16'd16384;
    localparam logic [15:0] ALPHA_FLOOR = 16'd164;
    localparam logic [35:0] DIST_SAT    = 36'hF_FFFF_FFFF;

    localparam logic [1:0] REQ_LOAD     = 2'd0;
    localparam logic [1:0] REQ_TRAIN    = 2'd1;
    localparam logic [1:0] REQ_CLASSIFY = 2'd2;

    localparam logic [2:0] CFG_ROWS  = 3'd0;
    localparam logic [2:0] CFG_COLS  = 3'd1;
    localparam logic [2:0] CFG_FEATS = 3'd2;
    localparam logic [2:0] CFG_EPOCH = 3'd3;
    localparam logic [2:0] CFG_SPE   = 3'd4;

    typedef struct packed {
        logic              have;
        logic [35:0]       dsq;
        logic [CRD_W-1:0]  row;
        logic [CRD_W-1:0]  col;
    } t_best;

    typedef struct packed {
        logic               clr;
        logic               rd_en;
        logic               upd;
        logic [7:0]         rd_addr;
        logic signed [15:0] x;
        logic               h_we;
        logic [CRD_W-1:0]   h_eta;
        logic [15:0]        h_val;
        logic [CRD_W-1:0]   win_row;
        logic [CRD_W-1:0]   win_col;
        logic [6:0]         rows;
        logic [6:0]         cols;
    } t_cell_ctl;

    typedef struct packed {
        logic        en;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [7:0]  addr;
        logic [15:0] val;
    } t_load;
endpackage

// ===== src/som_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module som_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [23:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [24:0] r_rem;
    logic [31:0] r_num;
    logic [23:0] r_den;
    logic [31:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [24:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem[23:0], r_num[31]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
            r_q   <= {r_q[30:0], ge};
            r_num <= {r_num[30:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== src/som_cell.sv =====
// One map cell: weight store, distance accumulator, update datapath and
// one stage of the winner search chain. Depends on som_pkg.
module som_cell import som_pkg::*; #(
    parameter int MAX_FEATURES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CRD_W-1:0] i_row,
    input  logic [CRD_W-1:0] i_col,
    input  t_cell_ctl        i_ctl,
    input  t_load            i_ld,
    input  t_best            i_best,
    output t_best            o_best
);
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    logic [15:0]        r_mem [MAX_FEATURES];
    logic               r_v1, r_v2;
    logic [FW-1:0]      r_a1, r_a2;
    logic signed [15:0] r_w1, r_w2;
    logic [33:0]        r_sq;
    logic signed [34:0] r_prod;
    logic [35:0]        r_acc;
    logic [15:0]        r_h;
    t_best              r_best;

    logic               active;
    logic [CRD_W-1:0]   dr, dc, eta;
    logic               ld_hit;
    logic signed [16:0] d;
    logic signed [33:0] sq_full;
    logic signed [34:0] prod;
    logic signed [35:0] t_rnd;
    logic signed [21:0] sh;
    logic signed [22:0] s_new;
    logic [15:0]        w_new;
    logic [36:0]        sum;
    t_best              n_best;

    assign active = ({1'b0, i_row} < i_ctl.rows) && ({1'b0, i_col} < i_ctl.cols);
    assign dr  = (i_row >= i_ctl.win_row) ? i_row - i_ctl.win_row : i_ctl.win_row - i_row;
    assign dc  = (i_col >= i_ctl.win_col) ? i_col - i_ctl.win_col : i_ctl.win_col - i_col;
    assign eta = (dr > dc) ? dr : dc;

    assign ld_hit = i_ld.en && ({3'd0, i_ld.row} == i_row) && ({3'd0, i_ld.col} == i_col)
                    && (32'(i_ld.addr) < MAX_FEATURES);

    assign d       = {i_ctl.x[15], i_ctl.x} - {r_w1[15], r_w1};
    assign sq_full = d * d;
    assign prod    = $signed({2'b00, r_h}) * d;

    // round half up then floor shift by 2^14
    assign t_rnd = 36'(r_prod) + 36'sd8192;
    assign sh    = 22'(t_rnd >>> 14);
    assign s_new = 23'(r_w2) + 23'(sh);
    always_comb begin
        if (s_new > 23'sd32767)
            w_new = 16'h7FFF;
        else if (s_new < -23'sd32768)
            w_new = 16'h8000;
        else
            w_new = s_new[15:0];
    end

    assign sum = {1'b0, r_acc} + {3'b000, r_sq};

    always_comb begin
        if (active && (!i_best.have || r_acc < i_best.dsq)) begin
            n_best.have = 1'b1;
            n_best.dsq  = r_acc;
            n_best.row  = i_row;
            n_best.col  = i_col;
        end else begin
            n_best = i_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.rd_en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en)
            r_w1 <= r_mem[i_ctl.rd_addr[FW-1:0]];
        r_a1   <= i_ctl.rd_addr[FW-1:0];
        r_a2   <= r_a1;
        r_w2   <= r_w1;
        r_sq   <= unsigned'(sq_full);
        r_prod <= prod;
        r_best <= n_best;
        if (ld_hit)
            r_mem[i_ld.addr[FW-1:0]] <= i_ld.val;
        else if (r_v2 && i_ctl.upd && active)
            r_mem[r_a2] <= w_new;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
            r_h   <= '0;
        end else begin
            if (r_v2 && !i_ctl.upd)
                r_acc <= (sum > {1'b0, DIST_SAT}) ? DIST_SAT : sum[35:0];
            if (i_ctl.h_we && eta == i_ctl.h_eta)
                r_h <= i_ctl.h_val;
        end
    end

    assign o_best = r_best;
endmodule

// ===== src/som_train_and_classify_core.sv =====
// Self-organising map core: load words and sample features are accepted only while idle.
// After the last feature the result word follows the feature sweep (F features) and
// the search chain (N = MAX_ROWS*MAX_COLS cells).
// Training then derives alpha and each in-reach neighbourhood rate on the shared
// divider before updating the weights.
// Synchronous active-low reset clears control state; weights are not cleared.
`include "som_train_and_classify_core_defines.svh"
module som_train_and_classify_core import som_pkg::*; #(
    parameter int MAX_ROWS     = 8,
    parameter int MAX_COLS     = 8,
    parameter int MAX_FEATURES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // cell_row, cell_col, feature_index, value
    input  logic [1:0]  i_s_tuser,   // req_type
    input  logic        i_s_tlast,   // last_feature
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // winner_row, winner_col, winner_dist_sq
    output logic        o_m_tuser    // was_training
);
    localparam int N_CELLS = MAX_ROWS * MAX_COLS;
    localparam int FW      = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CW      = $clog2(N_CELLS + 64);

    typedef enum logic [3:0] {
        S_IDLE, S_DIST, S_SRCH, S_EMIT, S_ALPHA, S_AWAIT, S_REACH,
        S_HPREP, S_HDIV, S_HWAIT, S_HNEXT, S_UPD, S_EPOCH
    } t_state;

    t_state       r_state;
    logic [3:0]   r_rows, r_cols;
    logic [4:0]   r_feats;
    logic [9:0]   r_epoch_tot;
    logic [15:0]  r_spe;
    logic [4:0]   r_pos, r_used;
    logic [9:0]   r_epoch;
    logic [15:0]  r_samp;
    logic         r_train;
    logic [CW-1:0] r_cnt;
    logic [15:0]  r_buf [MAX_FEATURES];
    logic signed [15:0] r_xraw;
    logic         r_xok;
    logic         r_clr, r_rd_en, r_upd;
    logic [7:0]   r_rd_addr;
    logic [15:0]  r_alpha;
    logic [22:0]  r_reach, r_den;
    logic [CRD_W-1:0] r_eta, r_heta;
    logic         r_hwe;
    logic [15:0]  r_hval;
    logic [CRD_W-1:0] r_win_row, r_win_col;
    logic         r_div_start;
    logic [31:0]  r_div_num;
    t_load        r_ld;
    logic         r_out_valid;
    logic [2:0]   r_out_row, r_out_col;
    logic [35:0]  r_out_dist;
    logic         r_out_train;

    logic [6:0]   cnt_r, cnt_c, span;
    logic [4:0]   cnt_f;
    logic [9:0]   e_eff;
    logic [15:0]  spe_eff;
    logic signed [11:0] num;
    logic         s_hs, m_hs;
    logic         div_busy, div_done;
    logic [31:0]  div_quot;
    t_cell_ctl    ctl;
    t_best        w_best [N_CELLS+1];

    assign cnt_r = (r_rows == 4'd0) ? 7'd1 :
                   (32'(r_rows) > MAX_ROWS) ? 7'(MAX_ROWS) : {3'd0, r_rows};
    assign cnt_c = (r_cols == 4'd0) ? 7'd1 :
                   (32'(r_cols) > MAX_COLS) ? 7'(MAX_COLS) : {3'd0, r_cols};
    assign cnt_f = (r_feats == 5'd0) ? 5'd1 :
                   (32'(r_feats) > MAX_FEATURES) ? 5'(MAX_FEATURES) : r_feats;
    assign span    = (cnt_r > cnt_c) ? cnt_r : cnt_c;
    assign e_eff   = (r_epoch_tot == 10'd0) ? 10'd1 : r_epoch_tot;
    assign spe_eff = (r_spe == 16'd0) ? 16'd1 : r_spe;
    assign num     = $signed({2'b00, e_eff}) + 12'sd1 - $signed({2'b00, r_epoch});

    assign o_s_tready = (r_state == S_IDLE);
    assign s_hs = i_s_tvalid && o_s_tready;
    assign m_hs = r_out_valid && i_m_tready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= 4'd8;
            r_cols      <= 4'd8;
            r_feats     <= 5'd16;
            r_epoch_tot <= 10'd10;
            r_spe       <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS:  r_rows      <= i_cfg_data[3:0];
                CFG_COLS:  r_cols      <= i_cfg_data[3:0];
                CFG_FEATS: r_feats     <= i_cfg_data[4:0];
                CFG_EPOCH: r_epoch_tot <= i_cfg_data[9:0];
                CFG_SPE:   r_spe       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample buffer
    always_ff @(posedge i_clk) begin
        if (s_hs && (i_s_tuser inside {REQ_TRAIN, REQ_CLASSIFY}) && r_pos < cnt_f)
            r_buf[r_pos[FW-1:0]] <= i_s_tdata[25:10];
        r_xraw <= $signed(r_buf[r_rd_addr[FW-1:0]]);
        r_xok  <= r_rd_addr[4:0] < r_used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_epoch     <= '0;
            r_samp      <= '0;
            r_cnt       <= '0;
            r_clr       <= 1'b0;
            r_rd_en     <= 1'b0;
            r_upd       <= 1'b0;
            r_hwe       <= 1'b0;
            r_div_start <= 1'b0;
            r_ld.en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ld.row    <= i_s_tdata[2:0];
            r_ld.col    <= i_s_tdata[5:3];
            r_ld.addr   <= {4'd0, i_s_tdata[9:6]};
            r_ld.val    <= i_s_tdata[25:10];
            r_clr       <= 1'b0;
            r_hwe       <= 1'b0;
            r_div_start <= 1'b0;
            r_rd_en     <= 1'b0;
            r_ld.en     <= 1'b0;
            // the emit state handles its own handshake
            if (m_hs && r_state != S_EMIT)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_hs) begin
                        case (i_s_tuser) inside
                            REQ_LOAD: begin
                                r_ld.en <= 1'b1;
                            end
                            REQ_TRAIN, REQ_CLASSIFY: begin
                                if (i_s_tlast) begin
                                    r_used  <= (r_pos < cnt_f) ? r_pos + 5'd1 : cnt_f;
                                    r_pos   <= '0;
                                    r_train <= (i_s_tuser == REQ_TRAIN);
                                    r_clr   <= 1'b1;
                                    r_upd   <= 1'b0;
                                    r_cnt   <= '0;
                                    r_state <= S_DIST;
                                end else if (r_pos < cnt_f) begin
                                    r_pos <= r_pos + 5'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIST, S_UPD: begin
                    r_rd_en   <= (r_cnt < CW'(cnt_f));
                    r_rd_addr <= 8'(r_cnt);
                    // hold the state until the accumulate/write-back of the last word has landed
                    if (r_cnt == CW'(cnt_f) + CW'(3)) begin
                        r_cnt   <= '0;
                        r_state <= (r_state == S_DIST) ? S_SRCH : S_EPOCH;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                    end
                end
                S_SRCH: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(N_CELLS))
                        r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= 3'(w_best[N_CELLS].row);
                        r_out_col   <= 3'(w_best[N_CELLS].col);
                        r_out_dist  <= w_best[N_CELLS].dsq;
                        r_out_train <= r_train;
                        r_win_row   <= w_best[N_CELLS].row;
                        r_win_col   <= w_best[N_CELLS].col;
                        r_state     <= r_train ? S_ALPHA : S_IDLE;
                    end
                end
                S_ALPHA: begin
                    if (num <= 12'sd0) begin
                        r_alpha <= ALPHA_FLOOR;
                        r_state <= S_REACH;
                    end else begin
                        r_div_num   <= (32'(num) << 14) + 32'(e_eff >> 1);
                        r_den       <= 23'(e_eff);
                        r_div_start <= 1'b1;
                        r_state     <= S_AWAIT;
                    end
                end
                S_AWAIT: begin
                    if (div_done) begin
                        r_alpha <= (div_quot < 32'(ALPHA_FLOOR)) ? ALPHA_FLOOR : div_quot[15:0];
                        r_state <= S_REACH;
                    end
                end
                S_REACH: begin
                    r_reach <= (23'(r_alpha) * 23'(span) < 23'(ONE_Q14)) ? 23'(ONE_Q14)
                                                                       : 23'(r_alpha) * 23'(span);
                    r_eta   <= '0;
                    r_state <= S_HPREP;
                end
                S_HPREP: begin
                    r_den <= 23'(r_alpha) * 23'(r_eta) + 23'(ONE_Q14);
                    if ({3'd0, r_eta, 14'd0} > r_reach) begin
                        r_hwe   <= 1'b1;
                        r_heta  <= r_eta;
                        r_hval  <= '0;
                        r_state <= S_HNEXT;
                    end else begin
                        r_state <= S_HDIV;
                    end
                end
                S_HDIV: begin
                    r_div_num   <= ({16'd0, r_alpha} << 14) + 32'(r_den >> 1);
                    r_div_start <= 1'b1;
                    r_state     <= S_HWAIT;
                end
                S_HWAIT: begin
                    if (div_done) begin
                        r_hwe   <= 1'b1;
                        r_heta  <= r_eta;
                        r_hval  <= div_quot[15:0];
                        r_state <= S_HNEXT;
                    end
                end
                S_HNEXT: begin
                    if ({1'b0, r_eta} == span - 7'd1) begin
                        r_upd   <= 1'b1;
                        r_cnt   <= '0;
                        r_state <= S_UPD;
                    end else begin
                        r_eta   <= r_eta + 1'b1;
                        r_state <= S_HPREP;
                    end
                end
                S_EPOCH: begin
                    r_upd <= 1'b0;
                    if ({1'b0, r_samp} + 17'd1 >= {1'b0, spe_eff}) begin
                        r_samp <= '0;
                        if (r_epoch != 10'd1023)
                            r_epoch <= r_epoch + 10'd1;
                    end else begin
                        r_samp <= r_samp + 16'd1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    som_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   ({1'b0, r_den}),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        ctl.clr     = r_clr;
        ctl.rd_en   = r_rd_en;
        ctl.upd     = r_upd;
        ctl.rd_addr = r_rd_addr;
        ctl.x       = r_xok ? r_xraw : 16'sd0;
        ctl.h_we    = r_hwe;
        ctl.h_eta   = r_heta;
        ctl.h_val   = r_hval;
        ctl.win_row = r_win_row;
        ctl.win_col = r_win_col;
        ctl.rows    = cnt_r;
        ctl.cols    = cnt_c;
    end

    assign w_best[0] = '0;

    for (genvar gr = 0; gr < MAX_ROWS; gr++) begin : g_row
        for (genvar gc = 0; gc < MAX_COLS; gc++) begin : g_col
            som_cell #(.MAX_FEATURES(MAX_FEATURES)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_row  (CRD_W'(gr)),
                .i_col  (CRD_W'(gc)),
                .i_ctl  (ctl),
                .i_ld   (r_ld),
                .i_best (w_best[gr*MAX_COLS+gc]),
                .o_best (w_best[gr*MAX_COLS+gc+1])
            );
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_dist, r_out_col, r_out_row};
    assign o_m_tuser  = r_out_train;

    `SOM_ASSERT(a_busy_after_last, s_hs && i_s_tlast && (i_s_tuser == REQ_TRAIN || i_s_tuser == REQ_CLASSIFY) |=> !o_s_tready, "core took a word while processing")
    `SOM_ASSERT(a_div_idle_start, r_div_start |-> !div_busy, "divider restarted while busy")
    `SOM_ASSERT(a_eta_in_span, r_hwe |-> ({1'b0, r_heta} < span), "rate broadcast beyond grid span")
    `SOM_ASSERT_ALWAYS(a_rate_only_train, r_hwe |-> r_train, "rate broadcast outside training")
endmodule
